// ----- design/ptd_pkg.sv -----
// Shared widths and handshake types for the trial-division primality tester.
// Used by ptd_rem_unit and primality_trial_division_unit; no dependencies.
package ptd_pkg;

    localparam int VALUE_WIDTH = 32;
    // Square of the running 6k bound; two extra bits cover the final overshoot
    localparam int SQ_W        = VALUE_WIDTH + 2;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);

    // Request from the sequencer to the remainder unit
    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [VALUE_WIDTH-1:0] divisor;
    } ptd_rem_req_t;

    // Status from the remainder unit back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } ptd_rem_stat_t;

endpackage

// ----- design/ptd_rem_unit.sv -----
// Bit-serial restoring remainder unit: one quotient bit per cycle.
// Depends on ptd_pkg for widths and the request/status structs.
module ptd_rem_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ptd_pkg::ptd_rem_req_t  req,
    output ptd_pkg::ptd_rem_stat_t stat
);
    import ptd_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   zero_reg, zero_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] dvd_reg, dvd_next;
    logic [VALUE_WIDTH-1:0] dsr_reg, dsr_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH:0]   trial;
    logic [VALUE_WIDTH-1:0] step_rem;

    // Shift in the next dividend bit and subtract when the divisor fits
    always_comb
    begin
        trial = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
        if (trial >= {1'b0, dsr_reg})
        begin
            step_rem = VALUE_WIDTH'(trial - {1'b0, dsr_reg});
        end
        else
        begin
            step_rem = trial[VALUE_WIDTH-1:0];
        end
    end

    // Sequence one remainder over VALUE_WIDTH steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        zero_next = zero_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VALUE_WIDTH - 1);
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = step_rem;
            dvd_next = {dvd_reg[VALUE_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                zero_next = (step_rem == '0);
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        cnt_reg  <= cnt_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign stat.zero = zero_reg;

endmodule

// ----- design/primality_trial_division_unit.sv -----
// Primality tester by trial division over 6k+1 and 6k+5.
// 0, 1, 2, 3, 5 and even numbers are decided at classification; otherwise one remainder
// each for 3 and 5, then two remainders per round of k plus one bound check, with
// rounds while (6k)^2 <= number (about 10900 rounds at 32 bits).
// One transaction at a time through the shared bit-serial remainder unit.
// Reset (rst_n, async, active low) empties the sequencer and output register.
module primality_trial_division_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ptd_pkg::VALUE_WIDTH-1:0] number,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            is_prime_flag
);
    import ptd_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLASS = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_BOUND = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    localparam logic [1:0] PH_THREE = 2'd0;
    localparam logic [1:0] PH_FIVE  = 2'd1;
    localparam logic [1:0] PH_KP1   = 2'd2;
    localparam logic [1:0] PH_KP5   = 2'd3;

    logic [2:0]             state_reg, state_next;
    logic [1:0]             phase_reg, phase_next;
    logic                   start_reg, start_next;
    logic                   res_reg, res_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_flag_reg, out_flag_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] k6_reg, k6_next;
    logic [VALUE_WIDTH-1:0] div_reg, div_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [SQ_W-1:0]        k6_wide;
    ptd_rem_req_t           rem_req;
    ptd_rem_stat_t          rem_stat;

    assign k6_wide = SQ_W'(k6_reg);

    ptd_rem_unit u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .stat  (rem_stat)
    );

    assign rem_req.start    = start_reg;
    assign rem_req.dividend = n_reg;
    assign rem_req.divisor  = div_reg;

    // Sequencer: classify, divide by 3 and 5, then walk 6k+1 and 6k+5
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        start_next     = 1'b0;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_flag_next  = out_flag_reg;
        n_next         = n_reg;
        k6_next        = k6_reg;
        div_next       = div_reg;
        sq_next        = sq_reg;

        // Drop the result once the sink takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    n_next     = number;
                    state_next = ST_CLASS;
                end
            end
            ST_CLASS:
            begin
                if (n_reg == VALUE_WIDTH'(2) || n_reg == VALUE_WIDTH'(3)
                    || n_reg == VALUE_WIDTH'(5))
                begin
                    res_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else if (n_reg[VALUE_WIDTH-1:1] == '0 || !n_reg[0])
                begin
                    res_next   = 1'b0;
                    state_next = ST_FIN;
                end
                else
                begin
                    div_next   = VALUE_WIDTH'(3);
                    start_next = 1'b1;
                    phase_next = PH_THREE;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.zero)
                    begin
                        res_next   = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_THREE:
                            begin
                                div_next   = VALUE_WIDTH'(5);
                                start_next = 1'b1;
                                phase_next = PH_FIVE;
                            end
                            PH_FIVE:
                            begin
                                k6_next    = VALUE_WIDTH'(6);
                                sq_next    = SQ_W'(36);
                                state_next = ST_BOUND;
                            end
                            PH_KP1:
                            begin
                                div_next   = k6_reg + VALUE_WIDTH'(5);
                                start_next = 1'b1;
                                phase_next = PH_KP5;
                            end
                            default:
                            begin
                                // (k6+6)^2 = k6^2 + 12*k6 + 36
                                k6_next    = k6_reg + VALUE_WIDTH'(6);
                                sq_next    = sq_reg + (k6_wide << 3) + (k6_wide << 2)
                                             + SQ_W'(36);
                                state_next = ST_BOUND;
                            end
                        endcase
                    end
                end
            end
            ST_BOUND:
            begin
                if (sq_reg > SQ_W'(n_reg))
                begin
                    res_next   = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    div_next   = k6_reg + VALUE_WIDTH'(1);
                    start_next = 1'b1;
                    phase_next = PH_KP1;
                    state_next = ST_WAIT;
                end
            end
            ST_FIN:
            begin
                // Hold the verdict until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_flag_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        phase_reg    <= phase_next;
        res_reg      <= res_next;
        out_flag_reg <= out_flag_next;
        n_reg        <= n_next;
        k6_reg       <= k6_next;
        div_reg      <= div_next;
        sq_reg       <= sq_next;
    end

    assign in_ready      = (state_reg == ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign is_prime_flag = out_flag_reg;

    // A remainder finishes only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        rem_stat.done |-> (state_reg == ST_WAIT))
        else $error("remainder finished outside the wait state");

    // A launched remainder keeps the unit busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |=> rem_stat.busy)
        else $error("remainder unit did not start");

    // The block takes no new transaction while the remainder unit works
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !rem_stat.busy)
        else $error("ready while remainder unit busy");

endmodule

// ----- test/primality_verdict_checker.sv -----
// Checker for the trial-division primality unit: predicts the verdict of every
// number taken in and compares it with every verdict handed out.
// Depends on ptd_pkg for the value width.
module primality_verdict_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  logic [ptd_pkg::VALUE_WIDTH-1:0] number,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic                            is_prime_flag,
    output int                              mismatch_count,
    output int                              verdicts_pending
);

    // Verdicts owed by the unit, oldest first, each with its number for the log
    typedef struct {
        logic [ptd_pkg::VALUE_WIDTH-1:0] value;
        bit                              prime;
    } owed_verdict_t;

    owed_verdict_t owed_verdicts[$];

    initial
    begin
        mismatch_count   = 0;
        verdicts_pending = 0;
    end

    // Trial division over 6k+1 and 6k+5 with an exact bound on k
    function automatic bit trial_division_verdict(logic [ptd_pkg::VALUE_WIDTH-1:0] value);
        longint unsigned n;
        longint unsigned k6;
        n = value;
        if (n == 2 || n == 3 || n == 5)
            return 1'b1;
        if (n < 2 || n % 2 == 0 || n % 3 == 0 || n % 5 == 0)
            return 1'b0;
        for (k6 = 6; k6 <= n / k6; k6 += 6)
        begin
            if (n % (k6 + 1) == 0 || n % (k6 + 5) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] verdict check: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Record each input transaction, then check each output transaction
    always @(posedge clk)
    begin
        owed_verdict_t oldest;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                oldest.value = number;
                oldest.prime = trial_division_verdict(number);
                owed_verdicts.push_back(oldest);
            end
            if (out_valid && out_ready)
            begin
                if (owed_verdicts.size() == 0)
                    report_mismatch($sformatf("verdict %0b with no number outstanding",
                                              is_prime_flag));
                else
                begin
                    oldest = owed_verdicts.pop_front();
                    if (is_prime_flag !== oldest.prime)
                        report_mismatch($sformatf("number %0d: is_prime_flag %0b, want %0b",
                                                  oldest.value, is_prime_flag, oldest.prime));
                end
            end
            verdicts_pending = owed_verdicts.size();
        end
    end

endmodule

// ----- test/tb_primality_trial_division_unit.sv -----
// Top of the primality unit testbench: clock, reset, number stimulus, receiver
// stalls, watchdog and final verdict. Depends on ptd_pkg, the unit and
// primality_verdict_checker.
module tb_primality_trial_division_unit;

    import ptd_pkg::*;

    // The largest prime needs the most rounds of all; leave ample margin
    localparam int WATCHDOG_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_ITEMS   = 72;
    localparam int PHASES         = 4;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [VALUE_WIDTH-1:0] number = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic                   is_prime_flag;

    int mismatch_count;
    int verdicts_pending;
    int gap_pct = 0;
    int stall_pct = 0;
    bit hold_start = 1'b0;
    int hold_left = 0;
    int quiet_cycles = 0;

    int unsigned small_factors[12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37};

    // Zero, one, small primes, squares and products hit by the first rounds,
    // numbers just past a loop bound, and the full-width extremes last
    logic [VALUE_WIDTH-1:0] directed_numbers[23] = '{
        32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd9, 32'd11,
        32'd13, 32'd25, 32'd31, 32'd37, 32'd47, 32'd49, 32'd77, 32'd121, 32'd143,
        32'd169, 32'h8000_0000, 32'hFFFF_FFFF, 32'd4294967291
    };

    primality_trial_division_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .number        (number),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .is_prime_flag (is_prime_flag)
    );

    primality_verdict_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .number           (number),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .is_prime_flag    (is_prime_flag),
        .mismatch_count   (mismatch_count),
        .verdicts_pending (verdicts_pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the output side at random, or hold it off entirely on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else if (hold_start)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Abort when no transaction moves on either side for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("primality_trial_division_unit: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one number after a random gap and hold it until taken
    task automatic offer_number(input logic [VALUE_WIDTH-1:0] value);
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        number   <= value;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid and wait until every owed verdict has come back
    task automatic wait_for_verdicts;
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (verdicts_pending != 0);
        @(posedge clk);
    endtask

    // Mostly small numbers; full-width ones carry a small factor so they end early
    function automatic logic [VALUE_WIDTH-1:0] pick_number();
        int          pick;
        int unsigned factor;
        pick = $urandom_range(99);
        if (pick < 10)
            return $urandom_range(255);
        if (pick < 80)
            return $urandom_range(16383);
        factor = small_factors[$urandom_range(11)];
        return factor * $urandom_range(32'hFFFF_FFFF / factor);
    endfunction

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed numbers, no idling
        foreach (directed_numbers[i])
            offer_number(directed_numbers[i]);
        wait_for_verdicts();

        // Hold the receiver off while numbers keep coming so the input stalls
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        offer_number(32'd97);
        offer_number(32'd91);
        offer_number(32'd1);
        offer_number(32'd2);
        offer_number(32'd89);
        wait_for_verdicts();

        // Random numbers: no idling, sender idle, receiver stalling, then both
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    gap_pct = 0;
                    stall_pct <= 0;
                end
                1:
                begin
                    gap_pct = 54;
                    stall_pct <= 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct <= 54;
                end
                default:
                begin
                    gap_pct = 29;
                    stall_pct <= 29;
                end
            endcase
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
            begin
                offer_number(pick_number());
                if ($urandom_range(19) == 0)
                    wait_for_verdicts();
            end
            wait_for_verdicts();
        end

        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("primality_trial_division_unit: match");
        else
            $display("primality_trial_division_unit: mismatch");
        $finish;
    end

endmodule

// ----- primality_trial_division_unit.f -----
design/ptd_pkg.sv
design/ptd_rem_unit.sv
design/primality_trial_division_unit.sv
test/primality_verdict_checker.sv
test/tb_primality_trial_division_unit.sv
